@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top-level rtl file of the primality tester
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/qrpt_pkg.sv @@
// shared types for the quadratic residue primality tester
// no dependencies
package qrpt_pkg;

  // one-bit verdict carried on the result channel
  typedef logic flag_t;

  // status returned by the shared modular adder
  typedef struct packed {
    logic wrap;   // sum reached the modulus and was reduced
    logic zero;   // reduced sum is zero
  } madd_flags_t;

endpackage

@@ rtl/core/qrpt_num_if.sv @@
// valid/ready channel carrying one candidate number
// no dependencies
interface qrpt_num_if #(
  parameter int unsigned WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

@@ rtl/core/qrpt_flag_if.sv @@
// valid/ready channel carrying one primality verdict
// depends on qrpt_pkg
interface qrpt_flag_if;
  import qrpt_pkg::*;

  logic  valid;
  logic  ready;
  flag_t is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

@@ rtl/core/quadratic_residue_primality_test.sv @@
// top level of the quadratic residue primality tester
// depends on qrpt_pkg, qrpt_num_if, qrpt_flag_if, qrpt_modadd, assert_macros.svh
//
//   channel    dir   interface      payload
//   num_in     in    qrpt_num_if    number   (WIDTH bits, unsigned)
//   flag_out   out   qrpt_flag_if   is_prime (1 bit)
//
// 1 is rejected and even numbers other than 2 are rejected without a search; 2 and 3
// pass without a search. An odd n >= 5 runs up to (n-3)/2 trials k, one at a time
// through the single shared modular adder. A hit ends the search early. Reset
// (rst, synchronous) returns to idle. num_in is ready only while idle; the verdict
// is held on flag_out until taken.
module quadratic_residue_primality_test #(
  parameter int unsigned WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  qrpt_num_if.sink     num_in,
  qrpt_flag_if.source  flag_out
);
  import qrpt_pkg::*;

  `include "assert_macros.svh"

  localparam logic [WIDTH-1:0] ONE   = WIDTH'(1);
  localparam logic [WIDTH-1:0] TWO   = WIDTH'(2);
  localparam logic [WIDTH-1:0] THREE = WIDTH'(3);

  typedef enum logic [1:0] {
    IDLE,   // waiting for a candidate
    PROD,   // test k*(k+1) mod n (odd trial offsets)
    SQR,    // step to (k+1)^2 mod n and test it (even trial offsets)
    DONE    // verdict waiting for transfer
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] n;        // candidate under test
  logic [WIDTH-1:0] m;        // (n-1)/2; the search stops when k+1 reaches it
  logic [WIDTH-1:0] k;        // trial index
  logic [WIDTH-1:0] s;        // k^2 mod n
  flag_t            verdict;

  logic [WIDTH-1:0] add_b;
  logic [WIDTH-1:0] add_sum;
  madd_flags_t      add_flags;
  logic [WIDTH-1:0] k_inc;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = num_in.valid && num_in.ready;
  assign out_xfer = flag_out.valid && flag_out.ready;
  assign k_inc    = k + ONE;

  // shared unit: adds k for the product test, 2k+1 for the square step
  assign add_b = (state == SQR) ? {k[WIDTH-2:0], 1'b1} : k;

  qrpt_modadd #(.WIDTH(WIDTH)) u_modadd (
    .a       (s),
    .b       (add_b),
    .modulus (n),
    .sum     (add_sum),
    .flags   (add_flags)
  );

  // handshake outputs
  assign num_in.ready      = (state == IDLE);
  assign flag_out.valid    = (state == DONE);
  assign flag_out.is_prime = verdict;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (in_xfer) begin
            n <= num_in.number;
            m <= num_in.number >> 1;
            k <= ONE;
            s <= ONE;
            if ((num_in.number == ONE) ||
                (!num_in.number[0] && (num_in.number != TWO))) begin
              verdict <= 1'b0;
              state   <= DONE;
            end else if ((num_in.number == TWO) || (num_in.number == THREE)) begin
              verdict <= 1'b1;
              state   <= DONE;
            end else begin
              state <= PROD;
            end
          end
        end
        PROD: begin
          // k*(k+1) = k^2 + k divisible by n marks a composite
          if (add_flags.zero) begin
            verdict <= 1'b0;
            state   <= DONE;
          end else begin
            state <= SQR;
          end
        end
        SQR: begin
          s <= add_sum;
          if (add_flags.zero) begin
            verdict <= 1'b0;
            state   <= DONE;
          end else if (k_inc == m) begin
            verdict <= 1'b1;
            state   <= DONE;
          end else begin
            k     <= k_inc;
            state <= PROD;
          end
        end
        DONE: begin
          if (out_xfer) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_IMPL(a_no_overlap, clk, rst, flag_out.valid, !num_in.ready)
  `ASSERT_IMPL(a_k_in_range, clk, rst, (state == PROD) || (state == SQR), (k < m) && (k != '0))
  `ASSERT_IMPL(a_s_reduced, clk, rst, (state == PROD) || (state == SQR), s < n)
  `ASSERT_NEXT(a_busy_after_in, clk, rst, in_xfer, !num_in.ready)
endmodule

@@ rtl/core/qrpt_modadd.sv @@
// shared modular adder: (a + b) mod modulus for a < modulus, b <= modulus
// depends on qrpt_pkg
module qrpt_modadd #(
  parameter int unsigned WIDTH = 16
) (
  input  logic [WIDTH-1:0]      a,
  input  logic [WIDTH-1:0]      b,
  input  logic [WIDTH-1:0]      modulus,
  output logic [WIDTH-1:0]      sum,
  output qrpt_pkg::madd_flags_t flags
);
  import qrpt_pkg::*;

  logic [WIDTH:0] sum_full;
  logic [WIDTH:0] sum_red;

  // one add, one compare, one conditional subtract
  assign sum_full   = {1'b0, a} + {1'b0, b};
  assign flags.wrap = (sum_full >= {1'b0, modulus});
  assign sum_red    = flags.wrap ? (sum_full - {1'b0, modulus}) : sum_full;
  assign sum        = sum_red[WIDTH-1:0];
  assign flags.zero = (sum == '0);
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for quadratic_residue_primality_test: directed and random candidates
// depends on qrpt_pkg, qrpt_num_if, qrpt_flag_if and the rtl of the tester
module testbench;
  import qrpt_pkg::*;

  localparam int unsigned WIDTH       = 16;
  localparam int unsigned RANDOM_ITEMS = 75;
  localparam int unsigned STALL_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 50;

  typedef logic [WIDTH-1:0] cand_t;

  // one directed candidate; the verdict is used only where known is set
  typedef struct {
    cand_t number;
    bit    known;
    flag_t verdict;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrpt_num_if #(.WIDTH(WIDTH)) num_ch ();
  qrpt_flag_if                 flag_ch ();

  quadratic_residue_primality_test #(.WIDTH(WIDTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .num_in   (num_ch.sink),
    .flag_out (flag_ch.source)
  );

  flag_t pending_verdicts[$];
  int    mismatches        = 0;
  int    verdicts_checked  = 0;
  int    primes_seen       = 0;
  int    idle_cycles       = 0;
  bit    steady            = 1'b0;
  bit    hold_done         = 1'b0;

  // trivial rejects, the empty searches of 2 and 3, field extremes, odd composites, primes
  directed_row_t directed_rows [25] = '{
    '{16'd0,     1'b1, 1'b0},
    '{16'd1,     1'b1, 1'b0},
    '{16'd2,     1'b1, 1'b1},
    '{16'd3,     1'b1, 1'b1},
    '{16'd4,     1'b1, 1'b0},
    '{16'd5,     1'b0, 1'b0},
    '{16'd7,     1'b0, 1'b0},
    '{16'd9,     1'b0, 1'b0},
    '{16'd15,    1'b0, 1'b0},
    '{16'd25,    1'b0, 1'b0},
    '{16'd49,    1'b0, 1'b0},
    '{16'd91,    1'b0, 1'b0},
    '{16'd97,    1'b0, 1'b0},
    '{16'd121,   1'b0, 1'b0},
    '{16'd127,   1'b0, 1'b0},
    '{16'd255,   1'b0, 1'b0},
    '{16'd257,   1'b0, 1'b0},
    '{16'd1021,  1'b0, 1'b0},
    '{16'd21845, 1'b0, 1'b0},
    '{16'd32749, 1'b0, 1'b0},
    '{16'd32768, 1'b1, 1'b0},
    '{16'd43690, 1'b1, 1'b0},
    '{16'd65521, 1'b0, 1'b0},
    '{16'd65534, 1'b1, 1'b0},
    '{16'd65535, 1'b0, 1'b0}
  };

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // residue search: composite as soon as some step lands on 1
  function automatic flag_t primality_verdict(input cand_t cand);
    longint unsigned n;
    longint unsigned j;
    longint unsigned d;
    longint unsigned t;
    n = longint'(cand);
    if (n == 1 || ((n & 1) == 0 && n != 2)) return 1'b0;
    for (j = 1; j + 2 < n; j++) begin
      d = n - j;
      t = (d * d + 3 + (j & 1)) / 4;
      if (t % n == 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly no gap, some short, a few long; none while steady
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random candidate: mostly small and odd, a few across the whole range
  function automatic cand_t pick_number();
    int unsigned r;
    cand_t n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = cand_t'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) n[0] = 1'b1;
    end else if (r < 90) begin
      n = cand_t'($urandom_range(256, 4095));
    end else if (r < 95) begin
      n = cand_t'($urandom());
      n[0] = 1'b0;
    end else begin
      n = cand_t'($urandom());
    end
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // offer one candidate, wait for the transfer, then queue its verdict
  task automatic offer_number(input cand_t n, input bit known, input flag_t verdict);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      num_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num_ch.valid  <= 1'b1;
    num_ch.number <= n;
    do @(posedge clk); while (!num_ch.ready);
    pending_verdicts.push_back(known ? verdict : primality_verdict(n));
  endtask

  // stimulus
  initial begin
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_number(directed_rows[i].number, directed_rows[i].known,
                   directed_rows[i].verdict);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = ((i / 25) % 2) == 1;
      offer_number(pick_number(), 1'b0, 1'b0);
    end
    steady = 1'b0;
    num_ch.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d directed and %0d random candidates, checked %0d verdicts (%0d prime)",
             $size(directed_rows), RANDOM_ITEMS, verdicts_checked, primes_seen);
    $display("receiver held off once for %0d cycles with the input stalled behind it",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[quadratic_residue_primality_test] OK");
    end else begin
      $display("[quadratic_residue_primality_test] ERROR");
    end
    $finish;
  end

  // receiver ready pattern, with one long hold-off once traffic is flowing
  initial begin
    int unsigned len;
    flag_ch.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!hold_done && verdicts_checked >= 30) begin
        hold_done = 1'b1;
        flag_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        len = pick_gap();
        if (len == 0) begin
          flag_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          flag_ch.ready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  // compare each verdict transfer with the oldest outstanding one
  always @(posedge clk) begin
    flag_t want;
    if (!rst && flag_ch.valid === 1'b1 && flag_ch.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %b with nothing outstanding", flag_ch.is_prime));
      end else begin
        want = pending_verdicts.pop_front();
        if (flag_ch.is_prime !== want)
          report_mismatch($sformatf("is_prime %b, expected %b", flag_ch.is_prime, want));
        if (want == 1'b1) primes_seen++;
        verdicts_checked++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (num_ch.valid && num_ch.ready) || (flag_ch.valid && flag_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
      $display("[quadratic_residue_primality_test] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/qrpt_pkg.sv
rtl/core/qrpt_num_if.sv
rtl/core/qrpt_flag_if.sv
rtl/core/qrpt_modadd.sv
rtl/core/quadratic_residue_primality_test.sv
verif/testbench.sv
